// File: src/mf3_pkg.sv
// Shared types and constants for the 3x3 RGB median filter.
// Used by the line buffer, median lanes, output queue and the top level.
`timescale 1ns / 1ps

package mf3_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int LB_AW      = $clog2(MAX_WIDTH);

    // Field and register widths
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Window and pipeline
    localparam int WIN_N       = 9;
    localparam int FLY_STAGES  = 4;
    localparam int Q_DEPTH     = 8;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    // Pixel packing: alpha[31:24] blue[23:16] green[15:8] red[7:0]
    typedef logic [31:0] t_pix;
    typedef logic [WIN_N-1:0][31:0] t_win;
    typedef logic [WIN_N-1:0][7:0]  t_lane_win;

    typedef struct packed {
        logic             valid;
        logic             has_int;
        logic             has_bord;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_pix             pix;
    } t_meta;

endpackage

// File: src/mf3_line_buf.sv
// Two line stores (one 64-bit wide memory) and the 3x3 pixel window.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_line_buf
    import mf3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_row,
    input  t_pix             i_pix,
    input  logic             i_has_int,
    input  logic             i_has_bord,
    output t_win             o_win,
    output t_meta            o_meta
);

    // entry layout: {row two above, row one above}
    logic [63:0] r_mem [MAX_WIDTH];
    logic [63:0] r_rd;
    t_meta       r_b_meta;
    t_meta       n_b_meta;
    t_meta       r_c_meta;
    t_win        r_win;

    logic [LB_AW-1:0] w_raddr;
    logic [LB_AW-1:0] w_waddr;
    logic [63:0]      w_wdata;
    logic             w_fwd;

    assign w_raddr = i_col[LB_AW-1:0];
    assign w_waddr = r_b_meta.col[LB_AW-1:0];
    assign w_wdata = {r_rd[31:0], r_b_meta.pix};
    // same column written this edge (width of one, or restart at column 0)
    assign w_fwd   = r_b_meta.valid && (w_waddr == w_raddr);

    always_comb begin
        n_b_meta          = '0;
        n_b_meta.valid    = i_acc;
        n_b_meta.has_int  = i_has_int;
        n_b_meta.has_bord = i_has_bord;
        n_b_meta.col      = i_col;
        n_b_meta.row      = i_row;
        n_b_meta.pix      = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_b_meta.valid) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            if (w_fwd) begin
                r_rd <= w_wdata;
            end else begin
                r_rd <= r_mem[w_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_meta.valid <= 1'b0;
            r_c_meta.valid <= 1'b0;
        end else begin
            r_b_meta <= n_b_meta;
            r_c_meta <= r_b_meta;
        end
    end

    // columns shift left, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (r_b_meta.valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_rd[63:32];
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= r_rd[31:0];
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_b_meta.pix;
        end
    end

    assign o_win  = r_win;
    assign o_meta = r_c_meta;

endmodule

// File: src/mf3_med_lane.sv
// One color lane: median of nine 8-bit values, two register stages.
// Sort columns, then max of lows / median of mids / min of highs.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_med_lane
    import mf3_pkg::*;
(
    input  logic       i_clk,
    input  t_lane_win  i_win,
    output logic [7:0] o_med
);

    function automatic logic [7:0] f_min(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] f_max(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [7:0] f_med3(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    logic [2:0][7:0] r_lo;
    logic [2:0][7:0] r_md;
    logic [2:0][7:0] r_hi;
    logic [7:0]      r_max_lo;
    logic [7:0]      r_med_md;
    logic [7:0]      r_min_hi;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_lo[j] <= f_min(f_min(i_win[j], i_win[3+j]), i_win[6+j]);
            r_md[j] <= f_med3(i_win[j], i_win[3+j], i_win[6+j]);
            r_hi[j] <= f_max(f_max(i_win[j], i_win[3+j]), i_win[6+j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_lo <= f_max(f_max(r_lo[0], r_lo[1]), r_lo[2]);
        r_med_md <= f_med3(r_md[0], r_md[1], r_md[2]);
        r_min_hi <= f_min(f_min(r_hi[0], r_hi[1]), r_hi[2]);
    end

    assign o_med = f_med3(r_max_lo, r_med_md, r_min_hi);

endmodule

// File: src/mf3_out_queue.sv
// Merge of lane medians with pixel metadata, result queue and beat sequencer.
// Each queue entry holds up to two results: interior median, then border pixel.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_out_queue
    import mf3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_meta            i_meta,
    input  logic [7:0]       i_alpha,
    input  logic [7:0]       i_med_r,
    input  logic [7:0]       i_med_g,
    input  logic [7:0]       i_med_b,
    input  logic             i_out_stall,
    output logic [Q_CW-1:0]  o_count,
    output logic             o_out_valid,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_alpha_out,
    output logic [COL_W-1:0] o_out_col,
    output logic [ROW_W-1:0] o_out_row,
    output logic             o_filtered,
    output logic             o_last_of_run
);

    typedef struct packed {
        logic             has_int;
        logic             has_bord;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_pix             pix;
        logic [7:0]       med_r;
        logic [7:0]       med_g;
        logic [7:0]       med_b;
        logic [7:0]       alpha;
    } t_entry;

    t_entry          r_q [Q_DEPTH];
    t_entry          w_new;
    t_entry          w_head;
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic            r_phase;
    logic            w_show_int;
    logic            w_beat;
    logic            w_pop;

    always_comb begin
        w_new.has_int  = i_meta.has_int;
        w_new.has_bord = i_meta.has_bord;
        w_new.col      = i_meta.col;
        w_new.row      = i_meta.row;
        w_new.pix      = i_meta.pix;
        w_new.med_r    = i_med_r;
        w_new.med_g    = i_med_g;
        w_new.med_b    = i_med_b;
        w_new.alpha    = i_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    assign w_head     = r_q[r_rp];
    assign w_show_int = w_head.has_int && !r_phase;

    assign o_out_valid   = (r_count != '0);
    assign o_red_out     = w_show_int ? w_head.med_r : w_head.pix[7:0];
    assign o_green_out   = w_show_int ? w_head.med_g : w_head.pix[15:8];
    assign o_blue_out    = w_show_int ? w_head.med_b : w_head.pix[23:16];
    assign o_alpha_out   = w_show_int ? w_head.alpha : w_head.pix[31:24];
    assign o_out_col     = w_show_int ? w_head.col - COL_W'(1) : w_head.col;
    assign o_out_row     = w_show_int ? w_head.row - ROW_W'(1) : w_head.row;
    assign o_filtered    = w_show_int;
    assign o_last_of_run = w_show_int ? !w_head.has_bord : 1'b1;

    assign w_beat = o_out_valid && !i_out_stall;
    assign w_pop  = w_beat && o_last_of_run;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_phase <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (w_pop) begin
                r_rp    <= r_rp + Q_AW'(1);
                r_phase <= 1'b0;
            end else if (w_beat) begin
                r_phase <= 1'b1;
            end
        end
    end

    assign o_count = r_count;

endmodule

// File: src/median_filter_3x3_rgb_core.sv
// Top level of the 3x3 RGB median filter: position counters, config registers,
// metadata delay line, and instances of line buffer, median lanes and queue.
// Depends on mf3_pkg, mf3_line_buf, mf3_med_lane, mf3_out_queue.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one RGBA pixel per beat in
//   raster order; i_frame_start puts the pixel at column 0, row 0.
//   Output channel (o_out_valid / i_out_stall) gives result beats with their
//   column and row. Border pixels come back unchanged (o_filtered = 0). An
//   interior pixel comes back as a median (o_filtered = 1) once its lower-right
//   neighbor is taken; an input may cause zero, one or two beats, and
//   o_last_of_run marks the last one.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   frame_width (index 0) and frame_height (index 1); write only while idle.
//   Throughput: one pixel per cycle while o_in_stall is low; the output port
//   moves one beat per cycle, so right-column and bottom-row pixels at column
//   and row two or more (two beats each) and receiver stalls fill the 8-entry
//   result queue, and o_in_stall rises once queue plus up to 4 pixels in the
//   pipeline reach 8.
//   Reset: counters at row 0 column 0, width 640, height 480, queue empty.
//   No clearing pass: line stores are filled by the first two rows of a frame.
`timescale 1ns / 1ps

module median_filter_3x3_rgb_core
    import mf3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    input  logic [7:0]            i_alpha_in,
    input  logic                  i_frame_start,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic [7:0]            o_alpha_out,
    output logic [COL_W-1:0]      o_out_col,
    output logic [ROW_W-1:0]      o_out_row,
    output logic                  o_filtered,
    output logic                  o_last_of_run,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [FW_W-1:0]       r_frame_width;
    logic [FH_W-1:0]       r_frame_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      n_row;
    logic [FLY_STAGES-1:0] r_fly;
    t_meta                 r_m1_meta;
    t_meta                 r_m2_meta;
    logic [7:0]            r_m1_alpha;
    logic [7:0]            r_m2_alpha;

    logic [FW_W-1:0]  w_width;
    logic [FH_W-1:0]  w_height;
    logic [COL_W-1:0] w_c0;
    logic [ROW_W-1:0] w_r0;
    logic             w_wrap;
    logic [FH_W-1:0]  w_r1;
    logic [COL_W-1:0] w_cur_col;
    logic [ROW_W-1:0] w_cur_row;
    logic [FW_W-1:0]  w_nc;
    logic [FH_W-1:0]  w_nr;
    logic             w_has_int;
    logic             w_has_bord;
    logic             w_acc;
    t_pix             w_pix;
    t_win             w_win;
    t_meta            w_c_meta;
    t_lane_win        w_win_r;
    t_lane_win        w_win_g;
    t_lane_win        w_win_b;
    logic [7:0]       w_med_r;
    logic [7:0]       w_med_g;
    logic [7:0]       w_med_b;
    logic [Q_CW-1:0]  w_q_count;
    logic [2:0]       w_fly_cnt;
    logic             w_push;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FW_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FH_W-1:0];
                end
            endcase
        end
    end

    // effective frame size, clamped
    always_comb begin
        if (r_frame_width == '0) begin
            w_width = FW_W'(1);
        end else if (r_frame_width > FW_W'(MAX_WIDTH)) begin
            w_width = FW_W'(MAX_WIDTH);
        end else begin
            w_width = r_frame_width;
        end
        if (r_frame_height == '0) begin
            w_height = FH_W'(1);
        end else if (r_frame_height > FH_W'(MAX_HEIGHT)) begin
            w_height = FH_W'(MAX_HEIGHT);
        end else begin
            w_height = r_frame_height;
        end
    end

    // position of the incoming pixel; counters past the frame wrap first
    always_comb begin
        w_c0      = i_frame_start ? '0 : r_col;
        w_r0      = i_frame_start ? '0 : r_row;
        w_wrap    = ({1'b0, w_c0} >= w_width);
        w_cur_col = w_wrap ? '0 : w_c0;
        w_r1      = {1'b0, w_r0} + FH_W'(w_wrap);
        w_cur_row = (w_r1 >= w_height) ? '0 : w_r1[ROW_W-1:0];

        w_nc = {1'b0, w_cur_col} + FW_W'(1);
        w_nr = {1'b0, w_cur_row} + FH_W'(1);
        if (w_nc >= w_width) begin
            n_col = '0;
            n_row = (w_nr >= w_height) ? '0 : w_nr[ROW_W-1:0];
        end else begin
            n_col = w_nc[COL_W-1:0];
            n_row = w_cur_row;
        end

        w_has_int  = (w_cur_col >= COL_W'(2)) && (w_cur_row >= ROW_W'(2));
        w_has_bord = (w_cur_col == '0) || ({1'b0, w_cur_col} == w_width - FW_W'(1))
                  || (w_cur_row == '0) || ({1'b0, w_cur_row} == w_height - FH_W'(1));
    end

    assign w_acc = i_in_valid && !o_in_stall;
    assign w_pix = {i_alpha_in, i_blue_in, i_green_in, i_red_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // pixels in flight that will push a queue entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fly <= '0;
        end else begin
            r_fly <= {r_fly[FLY_STAGES-2:0], w_acc && (w_has_int || w_has_bord)};
        end
    end

    always_comb begin
        w_fly_cnt = '0;
        for (int k = 0; k < FLY_STAGES; k++) begin
            w_fly_cnt = w_fly_cnt + 3'(r_fly[k]);
        end
    end

    assign o_in_stall = (5'(w_q_count) + 5'(w_fly_cnt)) >= 5'(Q_DEPTH);

    mf3_line_buf u_line_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_col      (w_cur_col),
        .i_row      (w_cur_row),
        .i_pix      (w_pix),
        .i_has_int  (w_has_int),
        .i_has_bord (w_has_bord),
        .o_win      (w_win),
        .o_meta     (w_c_meta)
    );

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            w_win_r[k] = w_win[k][7:0];
            w_win_g[k] = w_win[k][15:8];
            w_win_b[k] = w_win[k][23:16];
        end
    end

    mf3_med_lane u_lane_r (.i_clk(i_clk), .i_win(w_win_r), .o_med(w_med_r));
    mf3_med_lane u_lane_g (.i_clk(i_clk), .i_win(w_win_g), .o_med(w_med_g));
    mf3_med_lane u_lane_b (.i_clk(i_clk), .i_win(w_win_b), .o_med(w_med_b));

    // metadata follows the two lane stages; centre alpha taken with the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_meta.valid <= 1'b0;
            r_m2_meta.valid <= 1'b0;
        end else begin
            r_m1_meta <= w_c_meta;
            r_m2_meta <= r_m1_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_alpha <= w_win[4][31:24];
        r_m2_alpha <= r_m1_alpha;
    end

    assign w_push = r_m2_meta.valid && (r_m2_meta.has_int || r_m2_meta.has_bord);

    mf3_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_meta        (r_m2_meta),
        .i_alpha       (r_m2_alpha),
        .i_med_r       (w_med_r),
        .i_med_g       (w_med_g),
        .i_med_b       (w_med_b),
        .i_out_stall   (i_out_stall),
        .o_count       (w_q_count),
        .o_out_valid   (o_out_valid),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_alpha_out   (o_alpha_out),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_filtered    (o_filtered),
        .o_last_of_run (o_last_of_run)
    );

`ifndef NO_ASSERTIONS
    // the in-flight tracker and the metadata pipe agree on what reaches the queue
    a_fly_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fly[FLY_STAGES-1] == w_push)
        else $error("in-flight tracker out of step with metadata pipe");

    // queue plus in-flight entries never exceed the queue depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (5'(w_q_count) + 5'(w_fly_cnt)) <= 5'(Q_DEPTH))
        else $error("result queue overcommitted");

    // a median result never sits on the first row or column
    a_int_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_filtered) |-> (o_out_col != '0 && o_out_row != '0))
        else $error("median result at border position");

    // a beat that is not last must be followed by the border beat of the same pixel
    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=> (o_out_valid && !o_filtered))
        else $error("second beat of a pixel missing");
`endif

endmodule
